// File: design/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants for the region-of-interest mean color block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcm_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int CFG_W           = 14;
  localparam int IDX_W           = 3;
  localparam int SUM_W           = 32;
  localparam int AREA_W          = 25;
  localparam int QUO_W           = 9;
  localparam int BIT_W           = 4;

  localparam logic [IDX_W-1:0] REG_BOX_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_TOP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_COLS = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_ROWS = 3'd5;

  localparam logic [12:0] IMAGE_COLS_RESET = 13'd640;
  localparam logic [12:0] IMAGE_ROWS_RESET = 13'd480;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;    // a pixel word is taken this cycle
    logic             clip_load; // that word opens a frame: latch the clipped box
    logic             acc_en;    // the registered pixel is summed this cycle
    logic             div_load;  // last pixel of the frame: start the division
    logic             div_step;  // one quotient bit per cycle
    logic [BIT_W-1:0] bit_idx;   // quotient bit being resolved
  } cmd_t;

endpackage : rcm_pkg

`default_nettype wire

// File: design/roi_box_clip_color_mean_core.sv
// ----------------------------------------------------------------------------
// roi_box_clip_color_mean_core
// Mean color of a detection box clipped to the frame.
// ----------------------------------------------------------------------------
// Pixel words enter on in_valid/in_stall with their row, column and three
// byte lanes; frame_end marks the last word of a frame. The box registers
// on the cfg_write/cfg_index/cfg_data port are clipped to the frame size and
// latched by the first word of each frame. Within a frame one word is taken
// every cycle and summed per lane when it falls inside the box.
// After the frame_end word is taken, the input is stalled while per-lane
// restoring dividers with a shared divisor resolve the three means one
// quotient bit per cycle, with saturation at 255. The result word then
// shows on out_valid and holds, with the input still stalled, for as
// long as out_stall is high. Synchronous reset clears the sums, the
// latched box and the control state and restores the image size to
// 640 by 480 with an empty box.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_box_clip_color_mean_core
  import rcm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [11:0]      pixel_row,
  input  wire logic [11:0]      pixel_col,
  input  wire logic [7:0]       lane0,
  input  wire logic [7:0]       lane1,
  input  wire logic [7:0]       lane2,
  input  wire logic             frame_end,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [11:0]           clip_left,
  output logic [11:0]           clip_top,
  output logic [12:0]           clip_width,
  output logic [12:0]           clip_height,
  output logic [7:0]            mean0,
  output logic [7:0]            mean1,
  output logic [7:0]            mean2,
  output logic                  empty_box
);

  cmd_t cmd;

  rcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_frame_end (frame_end),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  rcm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .lane0       (lane0),
    .lane1       (lane1),
    .lane2       (lane2),
    .clip_left   (clip_left),
    .clip_top    (clip_top),
    .clip_width  (clip_width),
    .clip_height (clip_height),
    .mean0       (mean0),
    .mean1       (mean1),
    .mean2       (mean2),
    .empty_box   (empty_box)
  );

endmodule : roi_box_clip_color_mean_core

`default_nettype wire

// File: design/rcm_ctrl.sv
// ----------------------------------------------------------------------------
// rcm_ctrl
// Controller: frame tracking, input stall, division sequencing, output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_ctrl
  import rcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_frame_end,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(QUO_W - 1);

  logic [1:0]       state;
  logic [BIT_W-1:0] cnt;
  logic             s1_valid;
  logic             s1_last;
  logic             frame_open;
  logic             accept;

  // The word after a frame end is held off until the result has been taken.
  assign in_stall  = (state != ST_ACC) || (s1_valid && s1_last);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);

  always_comb begin
    cmd.accept    = accept;
    cmd.clip_load = accept && !frame_open;
    cmd.acc_en    = s1_valid;
    cmd.div_load  = s1_valid && s1_last;
    cmd.div_step  = (state == ST_DIV);
    cmd.bit_idx   = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACC;
      cnt        <= '0;
      s1_valid   <= 1'b0;
      s1_last    <= 1'b0;
      frame_open <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_last    <= in_frame_end;
        frame_open <= !in_frame_end;
      end
      case (state)
        ST_ACC: begin
          if (s1_valid && s1_last) begin
            state <= ST_DIV;
            cnt   <= TOP_BIT;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_OUT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state   <= ST_ACC;
            s1_last <= 1'b0;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

endmodule : rcm_ctrl

`default_nettype wire

// File: design/rcm_dp.sv
// ----------------------------------------------------------------------------
// rcm_dp
// Datapath: configuration registers, box clipping, lane sums and per-lane
// bit-per-cycle dividers, with a shared divisor, for the three lane means.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_dp
  import rcm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic              cfg_write,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [11:0]       pixel_row,
  input  wire logic [11:0]       pixel_col,
  input  wire logic [7:0]        lane0,
  input  wire logic [7:0]        lane1,
  input  wire logic [7:0]        lane2,
  output logic      [11:0]       clip_left,
  output logic      [11:0]       clip_top,
  output logic      [12:0]       clip_width,
  output logic      [12:0]       clip_height,
  output logic      [7:0]        mean0,
  output logic      [7:0]        mean1,
  output logic      [7:0]        mean2,
  output logic                   empty_box
);

  localparam logic [12:0] DIM_LIMIT = 13'(MAX_DIM);

  // Configuration registers.
  logic signed [12:0] box_left;
  logic signed [12:0] box_top;
  logic signed [13:0] box_width;
  logic signed [13:0] box_height;
  logic [12:0]        image_cols;
  logic [12:0]        image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_top    <= '0;
      box_width  <= '0;
      box_height <= '0;
      image_cols <= IMAGE_COLS_RESET;
      image_rows <= IMAGE_ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOX_LEFT:   box_left   <= cfg_data[12:0];
        REG_BOX_TOP:    box_top    <= cfg_data[12:0];
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        REG_IMAGE_COLS: image_cols <= cfg_data[12:0];
        REG_IMAGE_ROWS: image_rows <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Clipping of the configured box against the frame.
  logic [11:0] x_pos, y_pos;
  logic [12:0] w_pos, h_pos, cols, rows;
  logic [13:0] x_end, y_end;
  logic [12:0] w_clip, h_clip;

  always_comb begin
    x_pos = box_left[12]   ? 12'd0 : box_left[11:0];
    y_pos = box_top[12]    ? 12'd0 : box_top[11:0];
    w_pos = box_width[13]  ? 13'd0 : box_width[12:0];
    h_pos = box_height[13] ? 13'd0 : box_height[12:0];
    cols  = (image_cols > DIM_LIMIT) ? DIM_LIMIT : image_cols;
    rows  = (image_rows > DIM_LIMIT) ? DIM_LIMIT : image_rows;
    x_end = {2'b0, x_pos} + {1'b0, w_pos};
    y_end = {2'b0, y_pos} + {1'b0, h_pos};
    // A box that starts past the edge collapses to zero extent.
    if (x_end > {1'b0, cols}) begin
      w_clip = (cols > {1'b0, x_pos}) ? cols - {1'b0, x_pos} : 13'd0;
    end else begin
      w_clip = w_pos;
    end
    if (y_end > {1'b0, rows}) begin
      h_clip = (rows > {1'b0, y_pos}) ? rows - {1'b0, y_pos} : 13'd0;
    end else begin
      h_clip = h_pos;
    end
  end

  // Box latched when a frame opens.
  logic [11:0] bx_left, bx_top;
  logic [12:0] bx_width, bx_height, bx_right, bx_bottom;
  logic [AREA_W-1:0] area;

  always_ff @(posedge clk) begin
    if (rst) begin
      bx_left   <= '0;
      bx_top    <= '0;
      bx_width  <= '0;
      bx_height <= '0;
      bx_right  <= '0;
      bx_bottom <= '0;
    end else if (cmd.clip_load) begin
      bx_left   <= x_pos;
      bx_top    <= y_pos;
      bx_width  <= w_clip;
      bx_height <= h_clip;
      bx_right  <= {1'b0, x_pos} + w_clip;
      bx_bottom <= {1'b0, y_pos} + h_clip;
    end
  end

  always_ff @(posedge clk) begin
    area <= AREA_W'(bx_width) * AREA_W'(bx_height);
  end

  // Registered pixel word.
  logic [11:0] s1_row, s1_col;
  logic [7:0]  s1_lane [3];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_row     <= pixel_row;
      s1_col     <= pixel_col;
      s1_lane[0] <= lane0;
      s1_lane[1] <= lane1;
      s1_lane[2] <= lane2;
    end
  end

  logic in_box;
  assign in_box = (s1_row >= bx_top) && ({1'b0, s1_row} < bx_bottom) &&
                  (s1_col >= bx_left) && ({1'b0, s1_col} < bx_right);

  logic [SUM_W-1:0]   sums     [3];
  logic [SUM_W-1:0]   sum_next [3];
  logic [SUM_W-1:0]   rem      [3];
  logic [QUO_W-1:0]   quo      [3];
  logic [SUM_W:0]     divisor;

  assign divisor = (SUM_W + 1)'(area) << cmd.bit_idx;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign sum_next[k] = sums[k] + (in_box ? SUM_W'(s1_lane[k]) : '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        sums[k] <= '0;
      end else if (cmd.div_load) begin
        sums[k] <= '0;
      end else if (cmd.acc_en) begin
        sums[k] <= sum_next[k];
      end
    end

    // Restoring division, one quotient bit per cycle, highest bit first.
    always_ff @(posedge clk) begin
      if (cmd.div_load) begin
        rem[k] <= sum_next[k];
        quo[k] <= '0;
      end else if (cmd.div_step) begin
        if ({1'b0, rem[k]} >= divisor) begin
          rem[k]              <= SUM_W'({1'b0, rem[k]} - divisor);
          quo[k][cmd.bit_idx] <= 1'b1;
        end
      end
    end
  end

  function automatic logic [7:0] sat_mean(input logic [QUO_W-1:0] q, input logic empty);
    logic [7:0] m;
    if (empty) begin
      m = 8'd0;
    end else if (q[QUO_W-1]) begin
      m = 8'd255;
    end else begin
      m = q[7:0];
    end
    return m;
  endfunction

  assign empty_box   = (bx_width == '0) || (bx_height == '0);
  assign clip_left   = bx_left;
  assign clip_top    = bx_top;
  assign clip_width  = bx_width;
  assign clip_height = bx_height;
  assign mean0       = sat_mean(quo[0], empty_box);
  assign mean1       = sat_mean(quo[1], empty_box);
  assign mean2       = sat_mean(quo[2], empty_box);

endmodule : rcm_dp

`default_nettype wire

// File: design/rcm_checker.sv
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks for the region-of-interest mean color block.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             frame_end,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [12:0]      clip_width,
  input wire logic [12:0]      clip_height,
  input wire logic [7:0]       mean0,
  input wire logic [7:0]       mean1,
  input wire logic [7:0]       mean2,
  input wire logic             empty_box
);

  // A waiting result word is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean0) && $stable(mean1) &&
      $stable(mean2) && $stable(clip_width) && $stable(clip_height))
    else $error("result word changed while stalled");

  // No pixel word is taken while a result is pending.
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input not stalled while result pending");

  // An accepted frame end is followed by a stalled input.
  a_end_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && frame_end |=> in_stall)
    else $error("input not stalled after frame end");

  // An empty box reports zero means.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_box |-> mean0 == 8'd0 && mean1 == 8'd0 && mean2 == 8'd0)
    else $error("nonzero mean for empty box");

  // A non-empty box has both extents nonzero.
  a_box_extent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_box |-> clip_width != 13'd0 && clip_height != 13'd0)
    else $error("empty extent on non-empty box");

endmodule : rcm_checker

bind roi_box_clip_color_mean_core rcm_checker u_rcm_checker (.*);

`default_nettype wire

// File: verif/roi_mean_checker.sv
// ----------------------------------------------------------------------------
// roi_mean_checker
// Watches the configuration port and both word channels of the ROI mean
// block. It keeps its own copy of the box registers, clips the box at each
// frame start, sums the lanes and queues the expected result word on every
// frame_end word. Each result word taken from the block is compared field by
// field with the oldest expected word.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_mean_checker
  import rcm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire logic [11:0]      pixel_row,
  input  wire logic [11:0]      pixel_col,
  input  wire logic [7:0]       lane0,
  input  wire logic [7:0]       lane1,
  input  wire logic [7:0]       lane2,
  input  wire logic             frame_end,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire logic [11:0]      clip_left,
  input  wire logic [11:0]      clip_top,
  input  wire logic [12:0]      clip_width,
  input  wire logic [12:0]      clip_height,
  input  wire logic [7:0]       mean0,
  input  wire logic [7:0]       mean1,
  input  wire logic [7:0]       mean2,
  input  wire logic             empty_box,
  output int                    error_count,
  output int                    words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] width;
    logic [12:0] height;
    logic [7:0]  mean0;
    logic [7:0]  mean1;
    logic [7:0]  mean2;
    logic        empty;
  } roi_word_t;

  logic [12:0] left_r, top_r, cols_r, rows_r;
  logic [13:0] width_r, height_r;
  logic [31:0] lane_sum [3];
  int          box_x, box_y, box_w, box_h;
  bit          frame_open;
  roi_word_t   roi_words_q [$];
  int          errors = 0;

  assign error_count = errors;

  // Frame sizes above the block's limit count as the limit.
  function automatic int frame_dim(input logic [12:0] raw);
    return (raw > 13'(MAX_DIM_DEFAULT)) ? MAX_DIM_DEFAULT : int'(raw);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [7:0]  px [3];
    logic [7:0]  mean_v [3];
    logic [31:0] area, quo;
    int          cols, rows, r, c;
    bit          empty;
    roi_word_t   want;
    if (rst) begin
      left_r     = '0;
      top_r      = '0;
      width_r    = '0;
      height_r   = '0;
      cols_r     = IMAGE_COLS_RESET;
      rows_r     = IMAGE_ROWS_RESET;
      lane_sum   = '{default: '0};
      box_x      = 0;
      box_y      = 0;
      box_w      = 0;
      box_h      = 0;
      frame_open = 1'b0;
      roi_words_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BOX_LEFT:   left_r   = cfg_data[12:0];
          REG_BOX_TOP:    top_r    = cfg_data[12:0];
          REG_BOX_WIDTH:  width_r  = cfg_data;
          REG_BOX_HEIGHT: height_r = cfg_data;
          REG_IMAGE_COLS: cols_r   = cfg_data[12:0];
          REG_IMAGE_ROWS: rows_r   = cfg_data[12:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (roi_words_q.size() == 0) begin
          $error("result word with no expected word waiting");
          errors++;
        end else begin
          want = roi_words_q.pop_front();
          check_field("clip_left", want.left, clip_left);
          check_field("clip_top", want.top, clip_top);
          check_field("clip_width", want.width, clip_width);
          check_field("clip_height", want.height, clip_height);
          check_field("mean0", want.mean0, mean0);
          check_field("mean1", want.mean1, mean1);
          check_field("mean2", want.mean2, mean2);
          check_field("empty_box", want.empty, empty_box);
        end
      end

      if (in_valid && !in_stall) begin
        // The first word of a frame latches the clipped box.
        if (!frame_open) begin
          cols  = frame_dim(cols_r);
          rows  = frame_dim(rows_r);
          box_x = int'($signed(left_r));
          box_y = int'($signed(top_r));
          box_w = int'($signed(width_r));
          box_h = int'($signed(height_r));
          if (box_x < 0) box_x = 0;
          if (box_y < 0) box_y = 0;
          if (box_w < 0) box_w = 0;
          if (box_h < 0) box_h = 0;
          if (box_x + box_w > cols) box_w = cols - box_x;
          if (box_y + box_h > rows) box_h = rows - box_y;
          lane_sum   = '{default: '0};
          frame_open = 1'b1;
        end
        r     = int'(pixel_row);
        c     = int'(pixel_col);
        px[0] = lane0;
        px[1] = lane1;
        px[2] = lane2;
        if (r >= box_y && r < box_y + box_h && c >= box_x && c < box_x + box_w) begin
          for (int k = 0; k < 3; k++) lane_sum[k] += 32'(px[k]);
        end
        if (frame_end) begin
          empty = (box_w <= 0) || (box_h <= 0);
          area  = empty ? '0 : 32'(box_w * box_h);
          for (int k = 0; k < 3; k++) begin
            if (empty) begin
              mean_v[k] = '0;
            end else begin
              quo       = lane_sum[k] / area;
              mean_v[k] = (quo > 32'd255) ? 8'd255 : quo[7:0];
            end
          end
          want.left   = 12'(box_x);
          want.top    = 12'(box_y);
          want.width  = (box_w > 0) ? 13'(box_w) : '0;
          want.height = (box_h > 0) ? 13'(box_h) : '0;
          want.mean0  = mean_v[0];
          want.mean1  = mean_v[1];
          want.mean2  = mean_v[2];
          want.empty  = empty;
          roi_words_q.push_back(want);
          lane_sum   = '{default: '0};
          frame_open = 1'b0;
        end
      end
    end
    words_pending <= roi_words_q.size();
  end

endmodule : roi_mean_checker

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ROI box clip and mean color block.
// ----------------------------------------------------------------------------
// A short directed part covers corner boxes, negative extents, zero and
// oversized frames, saturation and single word frames. Then random phases
// each load a box setting and send raster scans and scattered words, with
// the sender and receiver idling in turn and one long receiver hold-off.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcm_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_WORDS  = 1000;

  // No register sits at this index; writes to it must be ignored.
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD} idle_mode_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic [11:0]      pixel_row = '0;
  logic [11:0]      pixel_col = '0;
  logic [7:0]       lane0     = '0;
  logic [7:0]       lane1     = '0;
  logic [7:0]       lane2     = '0;
  logic             frame_end = 1'b0;
  logic             out_stall = 1'b0;

  logic             in_stall, out_valid, empty_box;
  logic [11:0]      clip_left, clip_top;
  logic [12:0]      clip_width, clip_height;
  logic [7:0]       mean0, mean1, mean2;

  int               error_count, words_pending;
  idle_mode_t       idle_mode   = IDLE_NONE;
  int               hold_count  = 0;
  int               cycle_count = 0;
  int               words_sent  = 0;
  int               cur_left, cur_top, cur_cols, cur_rows;

  roi_box_clip_color_mean_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .lane0      (lane0),
    .lane1      (lane1),
    .lane2      (lane2),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .clip_left  (clip_left),
    .clip_top   (clip_top),
    .clip_width (clip_width),
    .clip_height(clip_height),
    .mean0      (mean0),
    .mean1      (mean1),
    .mean2      (mean2),
    .empty_box  (empty_box)
  );

  roi_mean_checker roi_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .lane0        (lane0),
    .lane1        (lane1),
    .lane2        (lane2),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .clip_left    (clip_left),
    .clip_top     (clip_top),
    .clip_width   (clip_width),
    .clip_height  (clip_height),
    .mean0        (mean0),
    .mean1        (mean1),
    .mean2        (mean2),
    .empty_box    (empty_box),
    .error_count  (error_count),
    .words_pending(words_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side. In the hold mode it stalls for a long stretch first, so
  // the block fills up and stalls its input while the sender keeps offering.
  always @(posedge clk) begin
    if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      if (idle_mode != IDLE_HOLD) hold_count <= 0;
      case (idle_mode)
        IDLE_RECV: out_stall <= ($urandom_range(99) < 55);
        IDLE_BOTH: out_stall <= ($urandom_range(99) < 11);
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [11:0] row, input logic [11:0] col,
                           input logic [7:0] l0, input logic [7:0] l1,
                           input logic [7:0] l2, input logic fe);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_row <= row;
    pixel_col <= col;
    lane0     <= l0;
    lane1     <= l1;
    lane2     <= l2;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Stop sending and wait until every expected result word has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_box(input int left, input int top, input int width,
                          input int height, input int cols, input int rows,
                          input idle_mode_t mode);
    logic [CFG_W-1:0] vals [6];
    logic [IDX_W-1:0] regs [6];
    regs = '{REG_BOX_LEFT, REG_BOX_TOP, REG_BOX_WIDTH,
             REG_BOX_HEIGHT, REG_IMAGE_COLS, REG_IMAGE_ROWS};
    // The top bit of a 13 bit register's write data is don't-care.
    vals[0] = {1'($urandom_range(1)), 13'(left)};
    vals[1] = {1'($urandom_range(1)), 13'(top)};
    vals[2] = 14'(width);
    vals[3] = 14'(height);
    vals[4] = {1'($urandom_range(1)), 13'(cols)};
    vals[5] = {1'($urandom_range(1)), 13'(rows)};
    if ($urandom_range(3) == 0) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
    end
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    idle_mode <= mode;
    cur_left  = left;
    cur_top   = top;
    cur_cols  = cols;
    cur_rows  = rows;
    @(posedge clk);
  endtask

  // Raster scan of a small frame; a second pass repeats every pixel.
  task automatic scan_frame(input int passes);
    int         style;
    logic [7:0] lv [3];
    style = $urandom_range(5);
    for (int p = 0; p < passes; p++) begin
      for (int r = 0; r < cur_rows; r++) begin
        for (int c = 0; c < cur_cols; c++) begin
          for (int k = 0; k < 3; k++) begin
            lv[k] = (style == 0) ? 8'd255 : (style == 1) ? 8'd0 : 8'($urandom);
          end
          send_word(12'(r), 12'(c), lv[0], lv[1], lv[2],
                    (p == passes - 1) && (r == cur_rows - 1) && (c == cur_cols - 1));
        end
      end
    end
  endtask

  // Words at arbitrary positions, mostly near the box corner.
  task automatic scatter_frame(input int count);
    int base_r, base_c;
    logic [11:0] row, col;
    base_r = (cur_top < 0) ? 0 : cur_top;
    base_c = (cur_left < 0) ? 0 : cur_left;
    for (int i = 0; i < count; i++) begin
      row = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(base_r + $urandom_range(7) - 2);
      col = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(base_c + $urandom_range(7) - 2);
      send_word(row, col, 8'($urandom), 8'($urandom), 8'($urandom), i == count - 1);
    end
  endtask

  initial begin
    int         phase, start_words, frames;
    int         left, top, width, height, cols, rows;
    idle_mode_t mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: zero sized box, and a word that opens and closes a frame.
    send_word(12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1);
    settle();

    // Box hanging off the top-left corner clips to the whole 4 by 3 frame.
    load_box(-5, -3, 9, 6, 4, 3, IDLE_NONE);
    send_word(12'd0, 12'd0, 8'd255, 8'd0, 8'd128, 1'b0);
    send_word(12'd2, 12'd3, 8'd255, 8'd255, 8'd255, 1'b0);
    send_word(12'd3, 12'd1, 8'd200, 8'd200, 8'd200, 1'b0);
    send_word(12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 1'b1);
    settle();

    // One pixel box in the far corner of a full frame; the repeat saturates.
    load_box(4095, 4095, 4096, 4096, 4096, 4096, IDLE_NONE);
    send_word(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b0);
    send_word(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 1'b1);
    settle();

    // Box starting past the right edge gives a negative width; rows oversized.
    load_box(100, 0, 10, 10, 50, 8191, IDLE_NONE);
    send_word(12'd0, 12'd100, 8'd77, 8'd88, 8'd99, 1'b1);
    settle();

    // Most negative position and a negative size on a zero sized frame.
    load_box(-4096, -4096, -4096, -4096, 0, 0, IDLE_NONE);
    send_word(12'd0, 12'd0, 8'd1, 8'd2, 8'd3, 1'b1);
    settle();

    // Widest box width and frame width, cut back to an oversized frame one row high.
    load_box(0, 0, 8191, 4096, 8191, 1, IDLE_NONE);
    send_word(12'd0, 12'd0, 8'd170, 8'd85, 8'd255, 1'b0);
    send_word(12'd0, 12'd4095, 8'd85, 8'd170, 8'd255, 1'b0);
    send_word(12'd1, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1);
    settle();

    phase       = 0;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      mode = (phase == 3) ? IDLE_HOLD : idle_mode_t'(phase % 4);
      if ($urandom_range(9) < 7) begin
        cols   = $urandom_range(1, 8);
        rows   = $urandom_range(1, 8);
        left   = int'($urandom_range(cols + 3)) - 2;
        top    = int'($urandom_range(rows + 3)) - 2;
        width  = int'($urandom_range(cols + 4)) - 2;
        height = int'($urandom_range(rows + 4)) - 2;
      end else begin
        cols   = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(8191));
        rows   = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(8191));
        left   = int'($urandom_range(8191)) - 4096;
        top    = int'($urandom_range(8191)) - 4096;
        width  = int'($urandom_range(16383)) - 8192;
        height = int'($urandom_range(16383)) - 8192;
      end
      load_box(left, top, width, height, cols, rows, mode);
      frames = (mode == IDLE_HOLD) ? 4 : int'($urandom_range(1, 4));
      for (int f = 0; f < frames; f++) begin
        if (cols >= 1 && cols <= 16 && rows >= 1 && rows <= 16 && $urandom_range(9) < 7) begin
          scan_frame(($urandom_range(9) == 0) ? 2 : 1);
        end else begin
          scatter_frame($urandom_range(1, 12));
        end
      end
      settle();
      phase++;
    end

    if (error_count == 0 && words_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
